// File: rtl/sla_pkg.sv
// Shared types and constants of the slot allocator.
`default_nettype none
package sla_pkg;

   localparam int POOL_SLOTS_DEF = 240;
   localparam int SLOT_W = 8;
   localparam int KEY_W = 16;
   localparam int TAG_W = 32;

   localparam logic [SLOT_W-1:0] NO_SLOT = 8'hFF;
   localparam logic [KEY_W-1:0] KEY_CLEAR = 16'hFFFF;
   localparam logic [TAG_W-1:0] TAG_CLEAR = 32'h0000_0000;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_RELEASE = 1'b1;

   localparam logic [1:0] STEP_LINK = 2'd0;
   localparam logic [1:0] STEP_MID = 2'd1;
   localparam logic [1:0] STEP_LAST = 2'd2;

   typedef struct packed {
      logic clear;
      logic accept;
      logic wr_en;
      logic [1:0] step;
      logic rsp_load;
   } sla_cmd_type;

   typedef struct packed {
      logic clear_last;
      logic noop;
      logic rsp_free;
   } sla_sts_type;

endpackage
`default_nettype wire

// File: rtl/sla_req_if.sv
// Request channel: allocate or release one slot.
`default_nettype none
interface sla_req_if;
   logic valid;
   logic ready;
   logic action;
   logic [sla_pkg::KEY_W-1:0] key;
   logic [sla_pkg::TAG_W-1:0] owner_tag;
   logic [sla_pkg::SLOT_W-1:0] slot;

   modport source (output valid, action, key, owner_tag, slot, input ready);
   modport sink (input valid, action, key, owner_tag, slot, output ready);
endinterface
`default_nettype wire

// File: rtl/sla_rsp_if.sv
// Response channel: granted slot and completion flag.
`default_nettype none
interface sla_rsp_if;
   logic valid;
   logic ready;
   logic [sla_pkg::SLOT_W-1:0] result_slot;
   logic done_res;

   modport source (output valid, result_slot, done_res, input ready);
   modport sink (input valid, result_slot, done_res, output ready);
endinterface
`default_nettype wire

// File: rtl/sla_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sla_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 240
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/sla_dpath.sv
// Datapath: list heads, link tables with clearing pass, key and tag store, response register.
`default_nettype none
module sla_dpath #(
   parameter int POOL_SLOTS = sla_pkg::POOL_SLOTS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire sla_pkg::sla_cmd_type cmd,
   output sla_pkg::sla_sts_type      sts,
   sla_req_if.sink                   req,
   sla_rsp_if.source                 rsp
);

   localparam int IDX_W = $clog2(POOL_SLOTS);
   localparam int SW = sla_pkg::SLOT_W;
   localparam int KT_W = sla_pkg::KEY_W + sla_pkg::TAG_W;
   localparam logic [SW-1:0] POOL_V = SW'(POOL_SLOTS);
   localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(POOL_SLOTS - 1);

   logic act_ff;
   logic [sla_pkg::KEY_W-1:0] key_ff;
   logic [sla_pkg::TAG_W-1:0] tag_ff;
   logic [SW-1:0] target_ff;
   logic in_range_ff;
   logic [SW-1:0] free_head_ff, free_head_in;
   logic [SW-1:0] used_head_ff, used_head_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0] rsp_slot_ff;
   logic rsp_done_ff;

   logic [SW-1:0] acc_target;
   logic acc_in_range;
   logic [IDX_W-1:0] acc_idx;

   logic [SW-1:0] clr_slot;
   logic [SW-1:0] clr_prev;
   logic [SW-1:0] clr_next;

   logic [SW-1:0] prev_rd;
   logic [SW:0] next_rd;
   logic [SW-1:0] eff_next;
   logic [SW-1:0] eff_prev;
   logic eff_used;
   logic noop;
   logic is_head;
   logic rsp_free;

   logic p_req;
   logic [SW-1:0] pwr_slot;
   logic [SW-1:0] pwr_data;
   logic pwr_en;
   logic n_req;
   logic [SW-1:0] nwr_slot;
   logic [SW:0] nwr_data;
   logic nwr_en;
   logic kt_en;
   logic [IDX_W-1:0] kt_addr;
   logic [KT_W-1:0] kt_data;

   assign acc_target = (req.action == sla_pkg::ACT_RELEASE) ? req.slot : free_head_ff;
   assign acc_in_range = acc_target < POOL_V;
   assign acc_idx = acc_target[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         act_ff <= req.action;
         key_ff <= req.key;
         tag_ff <= req.owner_tag;
         target_ff <= acc_target;
         in_range_ff <= acc_in_range;
      end
   end

   sla_ram #(.WIDTH(SW), .DEPTH(POOL_SLOTS)) u_prev_ram (
      .clock   (clock),
      .wr_en   (pwr_en),
      .wr_addr (pwr_slot[IDX_W-1:0]),
      .wr_data (pwr_data),
      .rd_en   (cmd.accept && acc_in_range),
      .rd_addr (acc_idx),
      .rd_data (prev_rd)
   );

   sla_ram #(.WIDTH(SW + 1), .DEPTH(POOL_SLOTS)) u_next_ram (
      .clock   (clock),
      .wr_en   (nwr_en),
      .wr_addr (nwr_slot[IDX_W-1:0]),
      .wr_data (nwr_data),
      .rd_en   (cmd.accept && acc_in_range),
      .rd_addr (acc_idx),
      .rd_data (next_rd)
   );

   sla_ram #(.WIDTH(KT_W), .DEPTH(POOL_SLOTS)) u_kt_ram (
      .clock   (clock),
      .wr_en   (kt_en),
      .wr_addr (kt_addr),
      .wr_data (kt_data),
      .rd_en   (1'b0),
      .rd_addr (target_ff[IDX_W-1:0]),
      .rd_data ()
   );

   // Reset links written by the clearing pass, one slot a cycle.
   assign clr_slot = SW'(clr_idx_ff);
   assign clr_prev = (clr_idx_ff == '0) ? sla_pkg::NO_SLOT : clr_slot - SW'(1);
   assign clr_next = (clr_idx_ff == CLR_LAST) ? sla_pkg::NO_SLOT : clr_slot + SW'(1);
   assign clr_idx_in = cmd.clear ? clr_idx_ff + IDX_W'(1) : clr_idx_ff;

   assign eff_used = next_rd[SW];
   assign eff_next = next_rd[SW-1:0];
   assign eff_prev = prev_rd;
   assign noop = !in_range_ff || ((act_ff == sla_pkg::ACT_RELEASE) && !eff_used);
   assign is_head = target_ff == used_head_ff;
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   assign sts.noop = noop;
   assign sts.rsp_free = rsp_free;
   assign sts.clear_last = clr_idx_ff == CLR_LAST;

   always_comb begin
      p_req = 1'b0;
      pwr_slot = sla_pkg::NO_SLOT;
      pwr_data = sla_pkg::NO_SLOT;
      n_req = 1'b0;
      nwr_slot = sla_pkg::NO_SLOT;
      nwr_data = {1'b0, sla_pkg::NO_SLOT};
      kt_en = 1'b0;
      kt_addr = target_ff[IDX_W-1:0];
      kt_data = {sla_pkg::KEY_CLEAR, sla_pkg::TAG_CLEAR};
      free_head_in = free_head_ff;
      used_head_in = used_head_ff;
      if (cmd.clear) begin
         p_req = 1'b1;
         pwr_slot = clr_slot;
         pwr_data = clr_prev;
         n_req = 1'b1;
         nwr_slot = clr_slot;
         nwr_data = {1'b0, clr_next};
         kt_en = 1'b1;
         kt_addr = clr_idx_ff;
      end else if (cmd.wr_en) begin
         unique case (cmd.step)
            sla_pkg::STEP_LINK: begin
               p_req = 1'b1;
               pwr_slot = eff_next;
               kt_en = 1'b1;
               if (act_ff == sla_pkg::ACT_ALLOC) begin
                  n_req = 1'b1;
                  nwr_slot = target_ff;
                  nwr_data = {1'b1, used_head_ff};
                  kt_data = {key_ff, tag_ff};
               end else begin
                  pwr_data = is_head ? sla_pkg::NO_SLOT : eff_prev;
                  n_req = !is_head;
                  nwr_slot = eff_prev;
                  nwr_data = {1'b1, eff_next};
               end
            end
            sla_pkg::STEP_MID: begin
               p_req = 1'b1;
               pwr_data = target_ff;
               if (act_ff == sla_pkg::ACT_ALLOC) begin
                  pwr_slot = used_head_ff;
               end else begin
                  pwr_slot = free_head_ff;
                  n_req = 1'b1;
                  nwr_slot = target_ff;
                  nwr_data = {1'b0, free_head_ff};
               end
            end
            sla_pkg::STEP_LAST: begin
               p_req = 1'b1;
               pwr_slot = target_ff;
               if (act_ff == sla_pkg::ACT_ALLOC) begin
                  free_head_in = eff_next;
                  used_head_in = target_ff;
               end else begin
                  free_head_in = target_ff;
                  if (is_head) begin
                     used_head_in = eff_next;
                  end
               end
            end
            default: begin
               p_req = 1'b0;
            end
         endcase
      end
   end

   assign pwr_en = p_req && (pwr_slot < POOL_V);
   assign nwr_en = n_req && (nwr_slot < POOL_V);

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff <= '0;
         used_head_ff <= sla_pkg::NO_SLOT;
         clr_idx_ff <= '0;
      end else begin
         free_head_ff <= free_head_in;
         used_head_ff <= used_head_in;
         clr_idx_ff <= clr_idx_in;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_slot_ff <= (noop || (act_ff == sla_pkg::ACT_RELEASE)) ? sla_pkg::NO_SLOT
                                                                   : target_ff;
         rsp_done_ff <= !noop;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.result_slot = rsp_slot_ff;
   assign rsp.done_res = rsp_done_ff;

`ifndef ASSERT_OFF
   a_heads_apart: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff != used_head_ff) || (free_head_ff == sla_pkg::NO_SLOT))
      else $error("free and used heads name the same slot");

   a_free_head_range: assert property (@(posedge clock) disable iff (reset)
      (free_head_ff < POOL_V) || (free_head_ff == sla_pkg::NO_SLOT))
      else $error("free head outside the pool");

   a_rsp_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp.ready))
      else $error("response overwritten while still pending");

   a_grant_from_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.wr_en && (cmd.step == sla_pkg::STEP_LAST) && (act_ff == sla_pkg::ACT_ALLOC))
      |-> (target_ff == free_head_ff))
      else $error("granted slot is not the free head");
`endif

endmodule
`default_nettype wire

// File: rtl/sla_ctrl.sv
// Controller: sequences the accept, link read and three table updates of each item.
`default_nettype none
module sla_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire sla_pkg::sla_sts_type sts,
   output sla_pkg::sla_cmd_type      cmd
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_LINK  = 6'b000010,
      ST_UPD2  = 6'b000100,
      ST_UPD3  = 6'b001000,
      ST_RESP  = 6'b010000,
      ST_CLEAR = 6'b100000
   } sla_state_type;

   sla_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      req_ready = 1'b0;
      cmd = '0;
      cmd.step = sla_pkg::STEP_LINK;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (sts.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = ST_LINK;
            end
         end
         ST_LINK: begin
            cmd.step = sla_pkg::STEP_LINK;
            cmd.wr_en = !sts.noop;
            state_in = sts.noop ? ST_RESP : ST_UPD2;
         end
         ST_UPD2: begin
            cmd.step = sla_pkg::STEP_MID;
            cmd.wr_en = 1'b1;
            state_in = ST_UPD3;
         end
         ST_UPD3: begin
            cmd.step = sla_pkg::STEP_LAST;
            cmd.wr_en = 1'b1;
            cmd.rsp_load = sts.rsp_free;
            state_in = sts.rsp_free ? ST_IDLE : ST_RESP;
         end
         ST_RESP: begin
            cmd.rsp_load = sts.rsp_free;
            if (sts.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef ASSERT_OFF
   a_accept_to_link: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == ST_LINK))
      else $error("accepted item did not start its link read");

   a_noop_no_write: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_LINK) && sts.noop) |-> !cmd.wr_en)
      else $error("table written for an ignored item");

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("item taken while the previous one is in progress");
`endif

endmodule
`default_nettype wire

// File: rtl/slot_allocator_free_used_lists.sv
// Top level of the slot allocator with free and used lists.
//
// Usage:
//   req carries one item: action 0 allocates the free head, action 1 releases
//   slot. key and owner_tag are stored with an allocated slot.
//   rsp returns one item per request: result_slot is the granted slot, or 255
//   on an empty pool and on every release; done_res marks a grant or a release
//   that took effect.
// Timing:
//   An item that changes the lists goes through accept, link read, and two more
//   link-table writes; an ignored item goes from the link read to the response.
//   The prev link table has one write port and a release or allocate rewrites
//   three of its entries; the result is registered before it appears on rsp.
// Reset:
//   Synchronous. All slots free in order from slot 0, used list empty; a
//   clearing pass over all POOL_SLOTS slots (240 by default) then writes the reset
//   links, and req.ready stays low until it ends.
// Back-pressure:
//   A result waits in the output register while rsp is stalled; the next item
//   is accepted and worked on, then holds until the register is free.
`default_nettype none
module slot_allocator_free_used_lists #(
   parameter int POOL_SLOTS = sla_pkg::POOL_SLOTS_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   sla_req_if.sink   req,
   sla_rsp_if.source rsp
);

   sla_pkg::sla_cmd_type cmd;
   sla_pkg::sla_sts_type sts;
   logic req_ready;

   sla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sla_dpath #(.POOL_SLOTS(POOL_SLOTS)) u_dpath (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .sts   (sts),
      .req   (req),
      .rsp   (rsp)
   );

   assign req.ready = req_ready;

endmodule
`default_nettype wire

// File: tb/sv/tb_slot_allocator_free_used_lists.sv
// Self-checking testbench for the slot allocator with free and used lists.
module tb_slot_allocator_free_used_lists;
   timeunit 1ns;
   timeprecision 1ps;

   import sla_pkg::*;

   localparam int POOL = POOL_SLOTS_DEF;
   localparam int PLAN_ROWS = 20;
   localparam int FILL_ITEMS = 280;
   localparam int RANDOM_ITEMS = 450;
   localparam int HOLD_AT = 120;
   localparam int HOLD_CYCLES = 200;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic action;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] owner_tag;
      logic [SLOT_W-1:0] slot;
   } alloc_req_t;

   typedef struct {
      logic [SLOT_W-1:0] result_slot;
      logic done_res;
   } grant_t;

   typedef struct {
      logic action;
      logic [KEY_W-1:0] key;
      logic [TAG_W-1:0] owner_tag;
      logic [SLOT_W-1:0] slot;
      bit typed;
      logic [SLOT_W-1:0] want_slot;
      logic want_done;
   } plan_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sla_req_if req_bus ();
   sla_rsp_if rsp_bus ();

   slot_allocator_free_used_lists dut (
      .clock(clock),
      .reset(reset),
      .req(req_bus),
      .rsp(rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Allocator state as the block should hold it.
   logic [SLOT_W-1:0] free_hd;
   logic [SLOT_W-1:0] used_hd;
   logic [SLOT_W-1:0] prev_lnk [POOL];
   logic [SLOT_W-1:0] next_lnk [POOL];
   logic [KEY_W-1:0] key_mem [POOL];
   logic [TAG_W-1:0] tag_mem [POOL];
   bit busy [POOL];

   grant_t grants_due [$];
   int unsigned mismatches = 0;
   int unsigned idle_cycles = 0;

   initial begin : clear_lists
      int i;
      for (i = 0; i < POOL; i++) begin
         prev_lnk[i] = (i == 0) ? NO_SLOT : SLOT_W'(i - 1);
         next_lnk[i] = (i == POOL - 1) ? NO_SLOT : SLOT_W'(i + 1);
         key_mem[i] = KEY_CLEAR;
         tag_mem[i] = TAG_CLEAR;
         busy[i] = 1'b0;
      end
      free_hd = '0;
      used_hd = NO_SLOT;
   end

   plan_row_t plan [PLAN_ROWS] = '{
      '{ACT_RELEASE, 16'h0000, 32'h0000_0000, NO_SLOT, 1'b1, NO_SLOT, 1'b0},
      '{ACT_RELEASE, 16'h0000, 32'h0000_0000, 8'h00,   1'b1, NO_SLOT, 1'b0},
      '{ACT_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, 8'hF0,   1'b1, NO_SLOT, 1'b0},
      '{ACT_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, 8'hFE,   1'b1, NO_SLOT, 1'b0},
      '{ACT_ALLOC,   16'h0000, 32'h0000_0000, NO_SLOT, 1'b1, 8'h00,   1'b1},
      '{ACT_ALLOC,   16'hFFFF, 32'hFFFF_FFFF, 8'h00,   1'b1, 8'h01,   1'b1},
      '{ACT_ALLOC,   16'h5A5A, 32'hA5A5_A5A5, 8'h7F,   1'b1, 8'h02,   1'b1},
      '{ACT_ALLOC,   16'hA5A5, 32'h5A5A_5A5A, 8'h80,   1'b1, 8'h03,   1'b1},
      '{ACT_RELEASE, 16'h1234, 32'h8765_4321, 8'h02,   1'b1, NO_SLOT, 1'b1},
      '{ACT_RELEASE, 16'h0000, 32'h0000_0000, 8'h02,   1'b1, NO_SLOT, 1'b0},
      '{ACT_RELEASE, 16'h0000, 32'h0000_0000, 8'h03,   1'b1, NO_SLOT, 1'b1},
      '{ACT_RELEASE, 16'h0000, 32'h0000_0000, 8'h00,   1'b1, NO_SLOT, 1'b1},
      '{ACT_ALLOC,   16'h0001, 32'h0000_0001, 8'hFF,   1'b0, NO_SLOT, 1'b0},
      '{ACT_ALLOC,   16'h8000, 32'h8000_0000, 8'h55,   1'b0, NO_SLOT, 1'b0},
      '{ACT_ALLOC,   16'h7FFF, 32'h7FFF_FFFF, 8'hAA,   1'b0, NO_SLOT, 1'b0},
      '{ACT_RELEASE, 16'h0000, 32'h0000_0000, 8'h01,   1'b0, NO_SLOT, 1'b0},
      '{ACT_RELEASE, 16'h0000, 32'h0000_0000, 8'hEF,   1'b1, NO_SLOT, 1'b0},
      '{ACT_ALLOC,   16'hC3C3, 32'h3C3C_3C3C, 8'h0F,   1'b0, NO_SLOT, 1'b0},
      '{ACT_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, 8'h00,   1'b0, NO_SLOT, 1'b0},
      '{ACT_RELEASE, 16'hFFFF, 32'hFFFF_FFFF, NO_SLOT, 1'b1, NO_SLOT, 1'b0}
   };

   function automatic grant_t predict_grant(alloc_req_t it);
      grant_t r;
      logic [SLOT_W-1:0] s;
      logic [SLOT_W-1:0] nxt;
      logic [SLOT_W-1:0] prv;
      logic [SLOT_W-1:0] old_hd;
      r.result_slot = NO_SLOT;
      r.done_res = 1'b0;
      if (it.action == ACT_ALLOC) begin
         s = free_hd;
         if (s < POOL) begin
            nxt = next_lnk[s];
            old_hd = used_hd;
            free_hd = nxt;
            if (nxt < POOL) prev_lnk[nxt] = NO_SLOT;
            if (old_hd < POOL) prev_lnk[old_hd] = s;
            used_hd = s;
            next_lnk[s] = old_hd;
            prev_lnk[s] = NO_SLOT;
            key_mem[s] = it.key;
            tag_mem[s] = it.owner_tag;
            busy[s] = 1'b1;
            r.result_slot = s;
            r.done_res = 1'b1;
         end
      end else if (it.slot < POOL && busy[it.slot]) begin
         s = it.slot;
         prv = prev_lnk[s];
         nxt = next_lnk[s];
         old_hd = free_hd;
         if (s == used_hd) begin
            used_hd = nxt;
            if (nxt < POOL) prev_lnk[nxt] = NO_SLOT;
         end else begin
            if (prv < POOL) next_lnk[prv] = nxt;
            if (nxt < POOL) prev_lnk[nxt] = prv;
         end
         if (old_hd < POOL) prev_lnk[old_hd] = s;
         next_lnk[s] = old_hd;
         prev_lnk[s] = NO_SLOT;
         free_hd = s;
         key_mem[s] = KEY_CLEAR;
         tag_mem[s] = TAG_CLEAR;
         busy[s] = 1'b0;
         r.done_res = 1'b1;
      end
      return r;
   endfunction

   // Fill the pool to empty first, then drain it; most releases name a used slot.
   function automatic alloc_req_t draw_item(int unsigned idx);
      alloc_req_t it;
      int unsigned alloc_pct;
      int unsigned start;
      int unsigned k;
      alloc_pct = (idx < FILL_ITEMS) ? 96 : 20;
      it.key = KEY_W'($urandom);
      it.owner_tag = TAG_W'($urandom);
      it.slot = SLOT_W'($urandom);
      if ($urandom_range(99) < alloc_pct) begin
         it.action = ACT_ALLOC;
      end else begin
         it.action = ACT_RELEASE;
         if ($urandom_range(99) < 85 && used_hd != NO_SLOT) begin
            start = $urandom_range(POOL - 1);
            for (k = 0; k < POOL; k++) begin
               if (busy[(start + k) % POOL]) begin
                  it.slot = SLOT_W'((start + k) % POOL);
                  break;
               end
            end
         end
      end
      return it;
   endfunction

   task automatic note_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
      if (mismatches < 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
      mismatches++;
   endtask

   initial begin : feed_requests
      alloc_req_t item;
      grant_t due;
      int unsigned gap;
      int unsigned n;
      req_bus.valid <= 1'b0;
      req_bus.action <= ACT_ALLOC;
      req_bus.key <= '0;
      req_bus.owner_tag <= '0;
      req_bus.slot <= NO_SLOT;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      gap = $urandom_range(0, 12);
      for (n = 0; n < PLAN_ROWS + RANDOM_ITEMS; n++) begin
         if (n < PLAN_ROWS) begin
            item.action = plan[n].action;
            item.key = plan[n].key;
            item.owner_tag = plan[n].owner_tag;
            item.slot = plan[n].slot;
         end else begin
            item = draw_item(n - PLAN_ROWS);
         end
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_bus.valid <= 1'b1;
         req_bus.action <= item.action;
         req_bus.key <= item.key;
         req_bus.owner_tag <= item.owner_tag;
         req_bus.slot <= item.slot;
         do @(posedge clock); while (!req_bus.ready);
         due = predict_grant(item);
         if (n < PLAN_ROWS && plan[n].typed) begin
            due.result_slot = plan[n].want_slot;
            due.done_res = plan[n].want_done;
         end
         grants_due.push_back(due);
         gap = (((n / 50) % 4) == 2) ? 0 : $urandom_range(0, 12);
      end
      req_bus.valid <= 1'b0;
      while (grants_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("slot_allocator_free_used_lists regression: pass");
      end else begin
         $display("slot_allocator_free_used_lists regression: fail");
      end
      $finish;
   end

   initial begin : take_results
      grant_t due;
      int unsigned stall;
      int unsigned got;
      rsp_bus.ready <= 1'b0;
      got = 0;
      wait (!reset);
      stall = $urandom_range(0, 12);
      forever begin
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         if (grants_due.size() == 0) begin
            note_mismatch("result with none pending, result_slot", NO_SLOT,
                          rsp_bus.result_slot);
         end else begin
            due = grants_due.pop_front();
            if (rsp_bus.result_slot !== due.result_slot)
               note_mismatch("result_slot", due.result_slot, rsp_bus.result_slot);
            if (rsp_bus.done_res !== due.done_res)
               note_mismatch("done_res", due.done_res, rsp_bus.done_res);
         end
         got++;
         // hold off for a long stretch so the block backs up into req
         if (got == HOLD_AT) stall = HOLD_CYCLES;
         else stall = (((got / 50) % 4) == 1) ? 0 : $urandom_range(0, 12);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("slot_allocator_free_used_lists regression: fail");
         $finish;
      end
   end

endmodule
